// File: sv/brx_pkg.sv
// Shared types and constants for the block frame receiver.
// No dependencies; imported by brx_core and block_frame_receiver.
package brx_pkg;

	localparam logic [7:0]  READY_MARK     = 8'h5A;
	localparam logic [7:0]  ACK_BYTE       = 8'hA5;
	localparam logic [15:0] MAX_LENGTH_RST = 16'd60000;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_BYTE  = 1'b1;

	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_OK       = 3'd1,
		ST_BAD_ACK  = 3'd2,
		ST_TOO_LONG = 3'd3,
		ST_CHECKSUM = 3'd4
	} status_t;

	// One result beat, before packing onto the output stream.
	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic [15:0] data_index;
		logic [15:0] block_length;
		logic        done_res;
		status_t     status;
	} brx_result_t;

	localparam int unsigned OUT_DATA_W = 56;

endpackage

// File: sv/brx_core.sv
// Frame protocol state machine: phase, running sum, length and byte count.
// Produces the result of one item combinationally; depends on brx_pkg.
module brx_core
	import brx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] max_length,
	output brx_result_t result
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ACK     = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_LEN_HI  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  sum_plus;
	logic [15:0] count_inc;
	logic [15:0] len_full;

	assign sum_plus  = sum_q + rx_byte;
	assign count_inc = count_q + 16'd1;
	assign len_full  = {rx_byte, len_q[7:0]};

	always_comb begin
		phase_d = phase_q;
		sum_d   = sum_q;
		len_d   = len_q;
		count_d = count_q;
		result  = '0;
		if (action == ACT_START) begin
			result.send_valid = 1'b1;
			result.send_byte  = READY_MARK;
			phase_d = PH_ACK;
			sum_d   = '0;
			len_d   = '0;
			count_d = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_ACK: begin
					if (rx_byte == ACK_BYTE) begin
						phase_d = PH_LEN_LO;
					end else begin
						result.done_res = 1'b1;
						result.status   = ST_BAD_ACK;
						phase_d = PH_IDLE;
					end
				end
				PH_LEN_LO: begin
					len_d   = {8'd0, rx_byte};
					sum_d   = sum_plus;
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len_d   = len_full;
					sum_d   = sum_plus;
					count_d = '0;
					if (len_full > max_length) begin
						result.done_res = 1'b1;
						result.status   = ST_TOO_LONG;
						phase_d = PH_IDLE;
					end else if (len_full == 16'd0) begin
						phase_d = PH_CHECK;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					result.data_valid = 1'b1;
					result.data_byte  = rx_byte;
					result.data_index = count_q;
					sum_d   = sum_plus;
					count_d = count_inc;
					if (count_inc >= len_q) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					result.done_res = 1'b1;
					phase_d = PH_IDLE;
					if (sum_plus == 8'd0) begin
						result.send_valid   = 1'b1;
						result.send_byte    = 8'd0 - sum_q;
						result.block_length = len_q;
						result.status       = ST_OK;
					end else begin
						result.status = ST_CHECKSUM;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sum_q   <= '0;
			len_q   <= '0;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			len_q   <= len_d;
			count_q <= count_d;
		end
	end

	// Payload bytes are only taken while the count is below the length.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> count_q < len_q)
		else $error("payload phase with count at or past length");

	// A start item always restarts the frame: the ack phase follows and the sum is cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && action == ACT_START |=> phase_q == PH_ACK && sum_q == 8'd0)
		else $error("start did not restart the frame");

	// A finished block always returns to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		step && result.done_res |=> phase_q == PH_IDLE)
		else $error("block ended without returning to idle");

endmodule

// File: sv/block_frame_receiver.sv
// Top level of the block frame receiver: input stage, protocol core, output register.
// Depends on brx_pkg and brx_core.
//
// Usage: every input beat on the s_ stream is one link event. s_tuser is the
// action (0 starts a block receive, 1 delivers one received link byte) and
// s_tdata is that byte. Every accepted beat produces exactly one output beat
// on the m_ stream: the byte to transmit to the partner (ready mark or checksum
// reply), a payload byte with its index, and on the beat that ends a block the
// status (and the length, for a good block), with m_tlast high.
// An accepted beat passes through the input register and then the output register.
// Throughput is one beat per cycle while m_tready stays high; the phase machine,
// its 8-bit sum adder and its 16-bit count incrementer sit between the two
// registers, so nothing iterates.
// The configuration channel writes max_length; it is always ready and should
// only be written while no block beat is in flight.
// Reset clears the phase machine to idle, empties both registers and loads
// max_length with 60000. When the receiver stalls m_tready, the result holds
// in the output register, the input register fills, and s_tready then drops
// until the output beat is taken.
module block_frame_receiver
	import brx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  logic                  s_tuser,   // [0] action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [0] send_valid, [8:1] send_byte, [9] data_valid, [17:10] data_byte,
	// [33:18] data_index, [49:34] block_length, [52:50] status, [55:53] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,   // done_res
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data
);

	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic [15:0] max_length_q;
	brx_result_t result;
	brx_result_t out_s2;
	logic        valid_s2;

	// The input stage moves on when the output register is empty or being drained.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_valid) begin
			max_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser;
			byte_s1   <= s_tdata;
		end
	end

	brx_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.action     (action_s1),
		.rx_byte    (byte_s1),
		.max_length (max_length_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = out_s2.done_res;
	assign m_tdata  = {3'd0, out_s2.status, out_s2.block_length, out_s2.data_index,
		out_s2.data_byte, out_s2.data_valid, out_s2.send_byte, out_s2.send_valid};

	// A successful block always carries the reply byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_s2.status == ST_OK |-> out_s2.done_res && out_s2.send_valid)
		else $error("ok status without reply byte");

	// A payload beat never ends a block.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_s2.data_valid |-> !out_s2.done_res && out_s2.status == ST_BUSY)
		else $error("payload beat carries end of block");

	// An ending beat always has a nonzero status.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_s2.done_res |-> out_s2.status != ST_BUSY)
		else $error("end of block without status");

	// An input beat waiting in the first stage blocks intake only while the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled without output backpressure");

endmodule
